// ===== rtl/cmbs_pkg.sv =====
`default_nettype none
package cmbs_pkg;

  localparam int MAX_FACE_SIZE_DEF = 256;
  localparam int CFG_DW = 9;
  localparam logic [CFG_DW-1:0] SIZE_RESET = 9'd256;
  localparam int QDEPTH = 2;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  typedef enum logic {
    CFG_FACE_WIDTH  = 1'b0,
    CFG_FACE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    FACE_PX = 3'd0,
    FACE_NX = 3'd1,
    FACE_PY = 3'd2,
    FACE_NY = 3'd3,
    FACE_PZ = 3'd4,
    FACE_NZ = 3'd5
  } face_t;

  typedef struct packed {
    logic        cmd;
    logic [2:0]  face;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [31:0] rgba;
    logic [15:0] mag;
    logic [16:0] num_u;
    logic [16:0] num_v;
  } cmbs_item_t;

  typedef logic [15:0] srgb_lut_t [256];

  function automatic int quot_width(input int max_size);
    return $clog2(256 * max_size + 1);
  endfunction

  function automatic int pipe_latency(input int max_size);
    return quot_width(max_size) + 8;
  endfunction

  function automatic logic [15:0] srgb_entry(input int unsigned i);
    longint unsigned e;
    longint unsigned a;
    longint unsigned a2;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned b2;
    longint unsigned b4;
    longint unsigned b5;
    longint unsigned q;
    if (i <= 10) begin
      e = (longint'(i) * 655350 * 2 + 32946) / 65892;
    end else begin
      a = ((longint'(1000 * i + 14025) << 31) + 134512) / 269025;
      a2 = (a * a + (longint'(1) << 30)) >> 31;
      lo = 0;
      hi = longint'(1) << 31;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        b2 = (mid * mid) >> 31;
        b4 = (b2 * b2) >> 31;
        b5 = (b4 * mid) >> 31;
        if (b5 <= a2) lo = mid;
        else hi = mid - 1;
      end
      q = (a2 * lo) >> 31;
      e = (q * 65535 + (longint'(1) << 30)) >> 31;
    end
    if (e > 65535) e = 65535;
    return e[15:0];
  endfunction

  function automatic srgb_lut_t build_srgb();
    srgb_lut_t t;
    for (int i = 0; i < 256; i++) t[i] = srgb_entry(i);
    return t;
  endfunction

  localparam srgb_lut_t SRGB_LUT = build_srgb();

endpackage
`default_nettype wire

// ===== rtl/cmbs_ram.sv =====
`default_nettype none
module cmbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/cmbs_div.sv =====
`default_nettype none
module cmbs_div #(
  parameter int DW = 33,
  parameter int QW = 17,
  parameter int MW = 16
) (
  input  wire logic          clk,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [MW-1:0] divisor,
  output logic      [QW-1:0] quot
);
  logic [MW-1:0] rem_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [QW-1:0] q_r   [QW];
  logic [MW-1:0] m_r   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [MW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] q_in;
    logic [MW-1:0] m_in;
    logic [MW:0]   t;
    logic [MW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = MW'(dividend >> QW);
      assign low_in = dividend[QW-1:0];
      assign q_in   = '0;
      assign m_in   = divisor;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign low_in = low_r[k-1];
      assign q_in   = q_r[k-1];
      assign m_in   = m_r[k-1];
    end

    assign t    = {rem_in, low_in[QW-1]};
    assign ge   = t >= {1'b0, m_in};
    assign diff = t - {1'b0, m_in};

    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? diff[MW-1:0] : t[MW-1:0];
      low_r[k] <= {low_in[QW-2:0], 1'b0};
      q_r[k]   <= {q_in[QW-2:0], ge};
      m_r[k]   <= m_in;
    end
  end

  assign quot = q_r[QW-1];
endmodule
`default_nettype wire

// ===== rtl/cmbs_front.sv =====
`default_nettype none
module cmbs_front import cmbs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_cmd,
  input  wire logic [2:0]  in_face_index,
  input  wire logic [7:0]  in_texel_col,
  input  wire logic [7:0]  in_texel_row,
  input  wire logic [31:0] in_texel_rgba,
  input  wire logic [15:0] in_dir_x,
  input  wire logic [15:0] in_dir_y,
  input  wire logic [15:0] in_dir_z,
  output logic             item_vld,
  output cmbs_item_t       item
);
  localparam int QPW = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH + 1);

  logic signed [16:0] xs, ys, zs, nxs, nys, nzs;
  logic [15:0] ax, ay, az, mag;
  logic signed [16:0] nu, nv;
  logic signed [17:0] su, sv;
  logic [2:0] face_sel;
  cmbs_item_t itm;

  cmbs_item_t     mem_r [QDEPTH];
  logic [QPW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic           push, pop;

  assign xs  = {in_dir_x[15], in_dir_x};
  assign ys  = {in_dir_y[15], in_dir_y};
  assign zs  = {in_dir_z[15], in_dir_z};
  assign nxs = -xs;
  assign nys = -ys;
  assign nzs = -zs;
  assign ax  = xs[16] ? nxs[15:0] : xs[15:0];
  assign ay  = ys[16] ? nys[15:0] : ys[15:0];
  assign az  = zs[16] ? nzs[15:0] : zs[15:0];

  always_comb begin
    if (ax >= ay && ax >= az) begin
      mag = ax;
      nv  = nys;
      if (!xs[16]) begin
        face_sel = FACE_PX;
        nu       = nzs;
      end else begin
        face_sel = FACE_NX;
        nu       = zs;
      end
    end else if (ay >= az) begin
      mag = ay;
      nu  = xs;
      if (!ys[16]) begin
        face_sel = FACE_PY;
        nv       = zs;
      end else begin
        face_sel = FACE_NY;
        nv       = nzs;
      end
    end else begin
      mag = az;
      nv  = nys;
      if (!zs[16]) begin
        face_sel = FACE_PZ;
        nu       = xs;
      end else begin
        face_sel = FACE_NZ;
        nu       = nxs;
      end
    end
    if (mag == '0) begin
      face_sel = FACE_PX;
      mag      = 16'd1;
      nu       = '0;
      nv       = '0;
    end
  end

  assign su = {nu[16], nu} + {2'b00, mag};
  assign sv = {nv[16], nv} + {2'b00, mag};

  always_comb begin
    itm.cmd   = in_cmd;
    itm.face  = (in_cmd == CMD_WRITE) ? in_face_index : face_sel;
    itm.col   = in_texel_col;
    itm.row   = in_texel_row;
    itm.rgba  = in_texel_rgba;
    itm.mag   = mag;
    itm.num_u = su[16:0];
    itm.num_v = sv[16:0];
  end

  assign busy     = cnt_r == QCW'(QDEPTH);
  assign push     = start && !busy;
  assign pop      = cnt_r != '0;
  assign item_vld = pop;
  assign item     = mem_r[rd_ptr_r];
  assign cnt_nxt  = cnt_r + QCW'(push) - QCW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= itm;
  end
endmodule
`default_nettype wire

// ===== rtl/cmbs_back.sv =====
`default_nettype none
module cmbs_back import cmbs_pkg::*; #(
  parameter int MAX_FACE_SIZE = MAX_FACE_SIZE_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              item_vld,
  input  wire cmbs_item_t        item,
  input  wire logic [CFG_DW-1:0] face_width,
  input  wire logic [CFG_DW-1:0] face_height,
  output logic                   out_valid,
  output logic [15:0]            out_red,
  output logic [15:0]            out_green,
  output logic [15:0]            out_blue,
  output logic [15:0]            out_alpha
);
  localparam int WB    = $clog2(MAX_FACE_SIZE + 1);
  localparam int XB    = $clog2(MAX_FACE_SIZE);
  localparam int QW    = quot_width(MAX_FACE_SIZE);
  localparam int PRW   = 17 + WB;
  localparam int DW    = PRW + 7;
  localparam int MW    = 16;
  localparam int PW    = XB + 8;
  localparam int HC    = (MAX_FACE_SIZE + 1) / 2;
  localparam int BD    = 6 * HC * HC;
  localparam int AW    = $clog2(BD);
  localparam int WDL   = QW + 3;

  logic [WB-1:0] w_eff, h_eff;

  always_comb begin
    if (face_width == '0) w_eff = WB'(1);
    else if (32'(face_width) > MAX_FACE_SIZE) w_eff = WB'(MAX_FACE_SIZE);
    else w_eff = WB'(face_width);
    if (face_height == '0) h_eff = WB'(1);
    else if (32'(face_height) > MAX_FACE_SIZE) h_eff = WB'(MAX_FACE_SIZE);
    else h_eff = WB'(face_height);
  end

  // dividend setup
  logic [PRW-1:0] prod_u, prod_v;
  logic           a_vld_r;
  logic [DW-1:0]  a_du_r, a_dv_r;
  logic [MW-1:0]  a_mag_r;
  logic [2:0]     a_face_r;

  assign prod_u = PRW'(item.num_u) * PRW'(w_eff);
  assign prod_v = PRW'(item.num_v) * PRW'(h_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else a_vld_r <= item_vld && item.cmd == CMD_SAMPLE;
  end

  always_ff @(posedge clk) begin
    a_du_r   <= {prod_u, 7'b0};
    a_dv_r   <= {prod_v, 7'b0};
    a_mag_r  <= item.mag;
    a_face_r <= item.face;
  end

  // texel writes, delayed to line up with the read stage
  logic          wr_ok;
  logic [AW-1:0] wr_addr;
  logic          wd_vld_r  [WDL];
  logic [1:0]    wd_bank_r [WDL];
  logic [AW-1:0] wd_addr_r [WDL];
  logic [31:0]   wd_data_r [WDL];

  assign wr_ok = item_vld && item.cmd == CMD_WRITE && item.face <= FACE_NZ &&
                 32'(item.col) < MAX_FACE_SIZE && 32'(item.row) < MAX_FACE_SIZE;
  assign wr_addr = AW'(32'(item.face) * (HC * HC) + 32'(item.row >> 1) * HC +
                       32'(item.col >> 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WDL; k++) wd_vld_r[k] <= 1'b0;
    end else begin
      wd_vld_r[0] <= wr_ok;
      for (int k = 1; k < WDL; k++) wd_vld_r[k] <= wd_vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    wd_bank_r[0] <= {item.row[0], item.col[0]};
    wd_addr_r[0] <= wr_addr;
    wd_data_r[0] <= item.rgba;
    for (int k = 1; k < WDL; k++) begin
      wd_bank_r[k] <= wd_bank_r[k-1];
      wd_addr_r[k] <= wd_addr_r[k-1];
      wd_data_r[k] <= wd_data_r[k-1];
    end
  end

  // u and v division
  logic [QW-1:0] quot_u, quot_v;
  logic          dv_vld_r  [QW];
  logic [2:0]    dv_face_r [QW];

  cmbs_div #(.DW(DW), .QW(QW), .MW(MW)) u_div_u (
    .clk(clk), .dividend(a_du_r), .divisor(a_mag_r), .quot(quot_u)
  );

  cmbs_div #(.DW(DW), .QW(QW), .MW(MW)) u_div_v (
    .clk(clk), .dividend(a_dv_r), .divisor(a_mag_r), .quot(quot_v)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QW; k++) dv_vld_r[k] <= 1'b0;
    end else begin
      dv_vld_r[0] <= a_vld_r;
      for (int k = 1; k < QW; k++) dv_vld_r[k] <= dv_vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    dv_face_r[0] <= a_face_r;
    for (int k = 1; k < QW; k++) dv_face_r[k] <= dv_face_r[k-1];
  end

  // texel position
  function automatic logic [PW-1:0] sat_pos(input logic [QW-1:0] s,
                                            input logic [WB-1:0] size);
    logic [QW-1:0] p;
    logic [QW-1:0] lim;
    p   = (s < QW'(128)) ? '0 : s - QW'(128);
    lim = QW'(size - 1'b1) << 8;
    return PW'((p > lim) ? lim : p);
  endfunction

  logic [PW-1:0] pos_u, pos_v;
  logic          p_vld_r;
  logic [XB-1:0] p_x0_r, p_y0_r;
  logic [7:0]    p_fx_r, p_fy_r;
  logic [2:0]    p_face_r;

  assign pos_u = sat_pos(quot_u, w_eff);
  assign pos_v = sat_pos(quot_v, h_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) p_vld_r <= 1'b0;
    else p_vld_r <= dv_vld_r[QW-1];
  end

  always_ff @(posedge clk) begin
    p_x0_r   <= pos_u[PW-1:8];
    p_fx_r   <= pos_u[7:0];
    p_y0_r   <= pos_v[PW-1:8];
    p_fy_r   <= pos_v[7:0];
    p_face_r <= dv_face_r[QW-1];
  end

  // bank addresses: bank index is {row parity, column parity}
  logic [AW-1:0] rd_addr [4];
  logic          r_vld_r;
  logic [AW-1:0] r_addr_r [4];
  logic [7:0]    r_fx_r, r_fy_r;
  logic          r_x0l_r, r_y0l_r;

  always_comb begin
    logic [XB:0] cb;
    logic [XB:0] rb;
    logic [1:0]  bi;
    for (int b = 0; b < 4; b++) begin
      bi = 2'(b);
      cb = (p_x0_r[0] == bi[0]) ? {1'b0, p_x0_r} : {1'b0, p_x0_r} + 1'b1;
      rb = (p_y0_r[0] == bi[1]) ? {1'b0, p_y0_r} : {1'b0, p_y0_r} + 1'b1;
      rd_addr[b] = AW'(32'(p_face_r) * (HC * HC) + 32'(rb >> 1) * HC + 32'(cb >> 1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) r_vld_r <= 1'b0;
    else r_vld_r <= p_vld_r;
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < 4; b++) r_addr_r[b] <= rd_addr[b];
    r_fx_r  <= p_fx_r;
    r_fy_r  <= p_fy_r;
    r_x0l_r <= p_x0_r[0];
    r_y0l_r <= p_y0_r[0];
  end

  // texel banks
  logic [31:0] bank_q [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    cmbs_ram #(.WIDTH(32), .DEPTH(BD)) u_ram (
      .clk  (clk),
      .we   (wd_vld_r[WDL-1] && wd_bank_r[WDL-1] == 2'(b)),
      .waddr(wd_addr_r[WDL-1]),
      .wdata(wd_data_r[WDL-1]),
      .raddr(r_addr_r[b]),
      .rdata(bank_q[b])
    );
  end

  logic       m_vld_r;
  logic [7:0] m_fx_r, m_fy_r;
  logic       m_x0l_r, m_y0l_r;

  always_ff @(posedge clk) begin
    if (!rst_n) m_vld_r <= 1'b0;
    else m_vld_r <= r_vld_r;
  end

  always_ff @(posedge clk) begin
    m_fx_r  <= r_fx_r;
    m_fy_r  <= r_fy_r;
    m_x0l_r <= r_x0l_r;
    m_y0l_r <= r_y0l_r;
  end

  // pick the four corners, replace zero-weight neighbors, decode
  logic [31:0] tex [4];
  logic [31:0] t10x, t11x;

  always_comb begin
    tex[0] = bank_q[{m_y0l_r, m_x0l_r}];
    t10x   = bank_q[{m_y0l_r, ~m_x0l_r}];
    tex[2] = bank_q[{~m_y0l_r, m_x0l_r}];
    t11x   = bank_q[{~m_y0l_r, ~m_x0l_r}];
    tex[1] = (m_fx_r == '0) ? tex[0] : t10x;
    tex[3] = (m_fx_r == '0) ? tex[2] : t11x;
    if (m_fy_r == '0) begin
      tex[2] = tex[0];
      tex[3] = tex[1];
    end
  end

  logic        l_vld_r;
  logic [15:0] l_c_r [4][4];
  logic [7:0]  l_fx_r, l_fy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) l_vld_r <= 1'b0;
    else l_vld_r <= m_vld_r;
  end

  always_ff @(posedge clk) begin
    for (int t = 0; t < 4; t++) begin
      for (int c = 0; c < 3; c++) l_c_r[t][c] <= SRGB_LUT[tex[t][8*c +: 8]];
      l_c_r[t][3] <= {tex[t][31:24], tex[t][31:24]};
    end
    l_fx_r <= m_fx_r;
    l_fy_r <= m_fy_r;
  end

  // horizontal blend
  logic [8:0]  wx0, wy0;
  logic        f_vld_r;
  logic [23:0] f_top_r [4];
  logic [23:0] f_bot_r [4];
  logic [7:0]  f_fy_r;

  assign wx0 = 9'd256 - {1'b0, l_fx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) f_vld_r <= 1'b0;
    else f_vld_r <= l_vld_r;
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      f_top_r[c] <= 24'(25'(l_c_r[0][c]) * 25'(wx0) + 25'(l_c_r[1][c]) * 25'(l_fx_r));
      f_bot_r[c] <= 24'(25'(l_c_r[2][c]) * 25'(wx0) + 25'(l_c_r[3][c]) * 25'(l_fx_r));
    end
    f_fy_r <= l_fy_r;
  end

  // vertical blend
  logic [31:0] blend [4];
  logic        o_vld_r;
  logic [15:0] o_ch_r [4];

  assign wy0 = 9'd256 - {1'b0, f_fy_r};

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      blend[c] = 32'(f_top_r[c]) * 32'(wy0) + 32'(f_bot_r[c]) * 32'(f_fy_r) + 32'd32768;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) o_vld_r <= 1'b0;
    else o_vld_r <= f_vld_r;
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) o_ch_r[c] <= blend[c][31:16];
  end

  assign out_valid = o_vld_r;
  assign out_red   = o_ch_r[0];
  assign out_green = o_ch_r[1];
  assign out_blue  = o_ch_r[2];
  assign out_alpha = o_ch_r[3];
endmodule
`default_nettype wire

// ===== rtl/cube_map_bilinear_sampler.sv =====
`default_nettype none
// Cube-map bilinear sampler.
// Input: an item is taken at a clock edge with start high and busy low.
//   in_cmd selects a texel write (face, column, row, sRGB RGBA word) or a
//   sample along the Q1.14 direction in_dir_x/y/z.
// Output: each sample gives one result word (linear R, G, B and alpha,
//   16 bits each) with out_valid high for one cycle. Writes give none.
//   The receiver cannot stall; results leave in issue order.
// Config: cfg_valid/cfg_ready write face_width (index 0) or face_height
//   (index 1); write them only while no item is in flight.
// Throughput: one item per cycle, every cycle. busy stays low since the
//   back end drains the queue each cycle.
// Divider: u and v are computed by a bit-per-stage divider
//   (quot_width = clog2(256*MAX+1) stages).
// Texels live in four parity banks so the four corners read in the same cycle.
// Reset: clears the pipeline and sets both sizes to 256. Texel memory is
//   not cleared; sample only texels that were written.
module cube_map_bilinear_sampler import cmbs_pkg::*; #(
  parameter int MAX_FACE_SIZE = MAX_FACE_SIZE_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              in_cmd,
  input  wire logic [2:0]        in_face_index,
  input  wire logic [7:0]        in_texel_col,
  input  wire logic [7:0]        in_texel_row,
  input  wire logic [31:0]       in_texel_rgba,
  input  wire logic [15:0]       in_dir_x,
  input  wire logic [15:0]       in_dir_y,
  input  wire logic [15:0]       in_dir_z,
  output logic                   out_valid,
  output logic [15:0]            out_red,
  output logic [15:0]            out_green,
  output logic [15:0]            out_blue,
  output logic [15:0]            out_alpha,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data
);
  logic [CFG_DW-1:0] face_width_r, face_height_r;
  logic              item_vld;
  cmbs_item_t        item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_width_r  <= SIZE_RESET;
      face_height_r <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FACE_WIDTH:  face_width_r  <= cfg_data;
        CFG_FACE_HEIGHT: face_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  cmbs_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cmd       (in_cmd),
    .in_face_index(in_face_index),
    .in_texel_col (in_texel_col),
    .in_texel_row (in_texel_row),
    .in_texel_rgba(in_texel_rgba),
    .in_dir_x     (in_dir_x),
    .in_dir_y     (in_dir_y),
    .in_dir_z     (in_dir_z),
    .item_vld     (item_vld),
    .item         (item)
  );

  cmbs_back #(.MAX_FACE_SIZE(MAX_FACE_SIZE)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_vld   (item_vld),
    .item       (item),
    .face_width (face_width_r),
    .face_height(face_height_r),
    .out_valid  (out_valid),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .out_alpha  (out_alpha)
  );
endmodule
`default_nettype wire

// ===== rtl/cmbs_checker.sv =====
`default_nettype none
module cmbs_checker import cmbs_pkg::*; #(
  parameter int MAX_FACE_SIZE = MAX_FACE_SIZE_DEF
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              in_cmd,
  input wire logic              out_valid,
  input wire logic              cfg_valid,
  input wire logic              cfg_ready
);
  localparam int LAT = pipe_latency(MAX_FACE_SIZE);

  logic take_sample;
  assign take_sample = start && !busy && in_cmd == CMD_SAMPLE;

  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word right after reset");

  a_no_backlog: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("queue backed up");

  a_fwd: assert property (@(posedge clk) disable iff (!rst_n)
      take_sample |-> ##LAT out_valid)
    else $error("sample word lost");

  a_bwd: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> $past(take_sample, LAT))
    else $error("result word without a sample");

  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
      cfg_valid |-> cfg_ready)
    else $error("config word refused");
endmodule

bind cube_map_bilinear_sampler cmbs_checker #(.MAX_FACE_SIZE(MAX_FACE_SIZE)) u_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_cmd   (in_cmd),
  .out_valid(out_valid),
  .cfg_valid(cfg_valid),
  .cfg_ready(cfg_ready)
);
`default_nettype wire

// ===== tb/sv/cube_map_bilinear_sampler_test.sv =====
`timescale 1ns / 1ps
module cube_map_bilinear_sampler_test;
  import cmbs_pkg::*;

  typedef struct {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_cmd = 1'b0;
  logic [2:0] in_face_index = '0;
  logic [7:0] in_texel_col = '0;
  logic [7:0] in_texel_row = '0;
  logic [31:0] in_texel_rgba = '0;
  logic [15:0] in_dir_x = '0;
  logic [15:0] in_dir_y = '0;
  logic [15:0] in_dir_z = '0;
  logic out_valid;
  logic [15:0] out_red, out_green, out_blue, out_alpha;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [CFG_DW-1:0] cfg_data = '0;

  pixel_t pixel_queue[$];
  logic [31:0] texel_mem[int];
  logic [15:0] linear_lut[256];
  int unsigned width_reg = 256;
  int unsigned height_reg = 256;
  int sender_idle_pct = 0;
  int item_count = 0;
  int mismatches = 0;
  int stall_cycles = 0;

  cube_map_bilinear_sampler dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_face_index(in_face_index), .in_texel_col(in_texel_col),
    .in_texel_row(in_texel_row), .in_texel_rgba(in_texel_rgba),
    .in_dir_x(in_dir_x), .in_dir_y(in_dir_y), .in_dir_z(in_dir_z),
    .out_valid(out_valid), .out_red(out_red), .out_green(out_green),
    .out_blue(out_blue), .out_alpha(out_alpha),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  function automatic longint unsigned fifth_power(input longint unsigned b);
    longint unsigned b2;
    longint unsigned b4;
    b2 = (b * b) >> 31;
    b4 = (b2 * b2) >> 31;
    return (b4 * b) >> 31;
  endfunction

  function automatic logic [15:0] gamma_decode(input int unsigned code);
    longint unsigned e;
    longint unsigned a;
    longint unsigned a2;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    if (code <= 10) begin
      e = (longint'(code) * 1310700 + 32946) / 65892;
    end else begin
      a = ((longint'(1000 * code + 14025) << 31) + 134512) / 269025;
      a2 = (a * a + (64'd1 << 30)) >> 31;
      lo = 0;
      hi = 64'd1 << 31;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (fifth_power(mid) <= a2) lo = mid;
        else hi = mid - 1;
      end
      e = ((((a2 * lo) >> 31) * 65535) + (64'd1 << 30)) >> 31;
    end
    if (e > 65535) e = 65535;
    return e[15:0];
  endfunction

  function automatic int eff_size(input int unsigned r);
    if (r == 0) return 1;
    if (r > 256) return 256;
    return r;
  endfunction

  function automatic int face_pos(input int num, input int mag, input int size);
    longint s;
    longint p;
    longint top;
    s = (longint'(num + mag) * size * 128) / mag;
    p = (s < 128) ? 0 : s - 128;
    top = longint'(size - 1) * 256;
    return int'((p > top) ? top : p);
  endfunction

  task automatic locate(input logic [15:0] dx, dy, dz, output int face,
                        output int x0, x1, y0, y1, fx, fy);
    int x, y, z, ax, ay, az, mag, nu, nv, w, h, px, py;
    x = int'($signed(dx));
    y = int'($signed(dy));
    z = int'($signed(dz));
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    az = z < 0 ? -z : z;
    if (ax >= ay && ax >= az) begin
      mag = ax;
      nv = -y;
      if (x >= 0) begin face = FACE_PX; nu = -z; end
      else begin face = FACE_NX; nu = z; end
    end else if (ay >= az) begin
      mag = ay;
      nu = x;
      if (y >= 0) begin face = FACE_PY; nv = z; end
      else begin face = FACE_NY; nv = -z; end
    end else begin
      mag = az;
      nv = -y;
      if (z >= 0) begin face = FACE_PZ; nu = x; end
      else begin face = FACE_NZ; nu = -x; end
    end
    if (mag == 0) begin
      face = FACE_PX; mag = 1; nu = 0; nv = 0;
    end
    w = eff_size(width_reg);
    h = eff_size(height_reg);
    px = face_pos(nu, mag, w);
    py = face_pos(nv, mag, h);
    x0 = px >> 8; fx = px & 255;
    y0 = py >> 8; fy = py & 255;
    x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
    y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
  endtask

  function automatic int texel_addr(input int face, input int col, input int row);
    return face * 65536 + row * 256 + col;
  endfunction

  function automatic longint chan(input logic [31:0] t, input int ch);
    logic [7:0] b;
    b = t[8*ch +: 8];
    return (ch == 3) ? longint'(b) * 257 : longint'(linear_lut[b]);
  endfunction

  function automatic pixel_t filter_pixel(input int face, x0, x1, y0, y1, fx, fy);
    pixel_t p;
    logic [31:0] t00, t10, t01, t11;
    longint top, bot, r;
    logic [15:0] res[4];
    t00 = texel_mem[texel_addr(face, x0, y0)];
    t10 = texel_mem[texel_addr(face, x1, y0)];
    t01 = texel_mem[texel_addr(face, x0, y1)];
    t11 = texel_mem[texel_addr(face, x1, y1)];
    for (int ch = 0; ch < 4; ch++) begin
      top = chan(t00, ch) * (256 - fx) + chan(t10, ch) * fx;
      bot = chan(t01, ch) * (256 - fx) + chan(t11, ch) * fx;
      r = (top * (256 - fy) + bot * fy + 32768) >> 16;
      res[ch] = r[15:0];
    end
    p.red = res[0]; p.green = res[1]; p.blue = res[2]; p.alpha = res[3];
    return p;
  endfunction

  task automatic send_word(input cmd_t cmd, input logic [2:0] face,
                           input logic [7:0] col, row, input logic [31:0] rgba,
                           input logic [15:0] dx, dy, dz);
    int f, x0, x1, y0, y1, fx, fy;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= cmd;
    in_face_index <= face;
    in_texel_col <= col;
    in_texel_row <= row;
    in_texel_rgba <= rgba;
    in_dir_x <= dx;
    in_dir_y <= dy;
    in_dir_z <= dz;
    do @(posedge clk); while (busy);
    item_count++;
    if (cmd == CMD_WRITE) begin
      if (face <= 5) texel_mem[texel_addr(face, col, row)] = rgba;
    end else begin
      locate(dx, dy, dz, f, x0, x1, y0, y1, fx, fy);
      pixel_queue.push_back(filter_pixel(f, x0, x1, y0, y1, fx, fy));
    end
  endtask

  task automatic write_texel(input logic [2:0] face, input logic [7:0] col, row,
                             input logic [31:0] rgba);
    send_word(CMD_WRITE, face, col, row, rgba, 16'($urandom), 16'($urandom),
              16'($urandom));
  endtask

  task automatic fill_if_empty(input int face, input int col, input int row);
    if (!texel_mem.exists(texel_addr(face, col, row)))
      write_texel(3'(face), 8'(col), 8'(row), $urandom);
  endtask

  task automatic sample_dir(input logic [15:0] dx, dy, dz);
    int f, x0, x1, y0, y1, fx, fy;
    locate(dx, dy, dz, f, x0, x1, y0, y1, fx, fy);
    fill_if_empty(f, x0, y0);
    fill_if_empty(f, x1, y0);
    fill_if_empty(f, x0, y1);
    fill_if_empty(f, x1, y1);
    send_word(CMD_SAMPLE, 3'($urandom), 8'($urandom), 8'($urandom), $urandom,
              dx, dy, dz);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_FACE_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  task automatic set_size(input logic [CFG_DW-1:0] w, input logic [CFG_DW-1:0] h);
    drain();
    write_reg(CFG_FACE_WIDTH, w);
    write_reg(CFG_FACE_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_comp();
    return 16'($urandom_range(0, 32768) - 16384);
  endfunction

  task automatic test_directed();
    sender_idle_pct = 0;
    write_texel(3'd0, 8'd255, 8'd255, 32'hFFFF_FFFF);
    write_texel(3'd5, 8'd0, 8'd0, 32'h0000_0000);
    write_texel(3'd6, 8'd1, 8'd1, 32'h1234_5678);
    write_texel(3'd7, 8'd255, 8'd0, 32'h8765_4321);
    sample_dir(16'sd16384, 16'sd0, 16'sd0);
    sample_dir(-16'sd16384, 16'sd0, 16'sd0);
    sample_dir(16'sd0, 16'sd16384, 16'sd0);
    sample_dir(16'sd0, -16'sd16384, 16'sd0);
    sample_dir(16'sd0, 16'sd0, 16'sd16384);
    sample_dir(16'sd0, 16'sd0, -16'sd16384);
    sample_dir(16'sd0, 16'sd0, 16'sd0);
    sample_dir(16'sd16384, 16'sd16384, 16'sd16384);
    sample_dir(-16'sd16384, 16'sd16384, -16'sd16384);
    sample_dir(16'sd16384, -16'sd16384, 16'sd16384);
    sample_dir(16'sd0, -16'sd1, 16'sd1);
    sample_dir(16'sd1, -16'sd1, -16'sd1);
  endtask

  task automatic test_random_sizes();
    int widths[10] = '{1, 0, 511, 256, 1, 3, 7, 2, 16, 5};
    int heights[10] = '{1, 511, 0, 1, 256, 5, 2, 9, 4, 256};
    int phase_end;
    for (int ph = 0; ph < 10; ph++) begin
      set_size(9'(widths[ph]), 9'(heights[ph]));
      case (ph % 3)
        0: sender_idle_pct = 0;
        1: sender_idle_pct = 58;
        default: sender_idle_pct = 8;
      endcase
      phase_end = item_count + 165;
      while (item_count < phase_end) begin
        if ($urandom_range(99) < 15)
          write_texel(3'($urandom), 8'($urandom), 8'($urandom), $urandom);
        else if ($urandom_range(99) < 20)
          sample_dir(rand_comp(), 16'($urandom_range(0, 64) - 32),
                     16'($urandom_range(0, 64) - 32));
        else
          sample_dir(rand_comp(), rand_comp(), rand_comp());
      end
    end
  endtask

  always @(posedge clk) begin
    pixel_t e;
    if (rst_n && out_valid) begin
      if (pixel_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h %h %h %h",
                                       out_red, out_green, out_blue, out_alpha);
      end else begin
        e = pixel_queue.pop_front();
        if (e.red !== out_red || e.green !== out_green || e.blue !== out_blue ||
            e.alpha !== out_alpha) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %h %h %h %h got %h %h %h %h", e.red, e.green,
                     e.blue, e.alpha, out_red, out_green, out_blue, out_alpha);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= 2000) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 256; i++) linear_lut[i] = gamma_decode(i);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_sizes();
    drain();
    if (mismatches == 0 && pixel_queue.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cmbs_pkg.sv
rtl/cmbs_ram.sv
rtl/cmbs_div.sv
rtl/cmbs_front.sv
rtl/cmbs_back.sv
rtl/cube_map_bilinear_sampler.sv
rtl/cmbs_checker.sv
tb/sv/cube_map_bilinear_sampler_test.sv
